// ===== sv/llt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, character constants and the character class table of the
// logic-language tokenizer. No dependencies.
package llt_pkg;

    localparam int MaxNameLenDefault      = 511;
    localparam int MaxCommentDepthDefault = 255;
    localparam int NameCapLimit           = 511;
    localparam int DepthW                 = 16;
    localparam int FifoDepth              = 4;

    localparam logic [16:0] HashMax  = 17'h1FFFF;
    localparam logic [31:0] IntMax   = 32'hFFFF_FFFF;
    localparam logic [15:0] ExpMax   = 16'hFFFF;
    localparam logic [3:0]  FracMaxD = 4'd9;

    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChNl    = 8'h0A;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChStar  = 8'h2A;
    localparam logic [7:0] ChPct   = 8'h25;
    localparam logic [7:0] ChE     = 8'h65;
    localparam logic [7:0] ChLBrk  = 8'h5B;
    localparam logic [7:0] ChRBrk  = 8'h5D;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChBar   = 8'h7C;

    typedef enum logic [1:0] {
        CFG_NESTED = 2'd0,
        CFG_COMMA  = 2'd1,
        CFG_BAR    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_VAR   = 3'd0,
        KIND_NAME  = 3'd1,
        KIND_PUNC  = 3'd2,
        KIND_BRACK = 3'd3,
        KIND_NUM   = 3'd4,
        KIND_NIL   = 3'd5,
        KIND_EOF   = 3'd6,
        KIND_ERR   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_ILLEGAL = 2'd1,
        ERR_QUOTE   = 2'd2,
        ERR_COMMENT = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        CL_END, CL_BLANK, CL_VARSTART, CL_LOWER, CL_DIGIT, CL_QUOTE,
        CL_SYM, CL_SOLO, CL_BRACK, CL_ILLEGAL
    } t_cls;

    typedef enum logic [15:0] {
        MODE_IDLE    = 16'h0001,
        MODE_VAR     = 16'h0002,
        MODE_NAME    = 16'h0004,
        MODE_SYM     = 16'h0008,
        MODE_PERIOD  = 16'h0010,
        MODE_INT     = 16'h0020,
        MODE_DOT     = 16'h0040,
        MODE_FRAC    = 16'h0080,
        MODE_EXP     = 16'h0100,
        MODE_ESIGN   = 16'h0200,
        MODE_EDIG    = 16'h0400,
        MODE_QUOTE   = 16'h0800,
        MODE_BRACKET = 16'h1000,
        MODE_LINE    = 16'h2000,
        MODE_BLOCK   = 16'h4000,
        MODE_REPLAY  = 16'h8000
    } t_mode;

    typedef struct packed {
        logic nested;
        logic comma_punc;
        logic bar_punc;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [7:0]        held;
        logic [7:0]        quote;
        logic [16:0]       hash;
        logic [8:0]        len;
        logic [31:0]       acc_int;
        logic [29:0]       acc_frac;
        logic [3:0]        frac_cnt;
        logic              exp_neg;
        logic [15:0]       acc_exp;
        logic [DepthW-1:0] depth;
    } t_state;

    localparam t_state StateReset = '{mode: MODE_IDLE, default: '0};

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tch;
        logic [16:0] hash;
        logic [8:0]  len;
        logic [31:0] int_part;
        logic [29:0] frac;
        logic [3:0]  frac_digits;
        logic        exp_neg;
        logic [15:0] exp_val;
        t_err        err;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_emit;

    typedef struct packed {
        t_state st;
        t_emit  em;
    } t_work;

    typedef struct packed {
        logic       space2;
        logic [2:0] count;
    } t_fifo_stat;

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls k;
        if (c == ChNul) k = CL_END;
        else if (c[7]) k = CL_ILLEGAL;
        else if (c <= 8'd32 || c == 8'd127) k = CL_BLANK;
        else if ((c >= "A" && c <= "Z") || c == "_") k = CL_VARSTART;
        else if ((c >= "a" && c <= "z") || c == "$") k = CL_LOWER;
        else if (c >= "0" && c <= "9") k = CL_DIGIT;
        else if (c == 8'h27 || c == 8'h22) k = CL_QUOTE;
        else if (c == "!" || c == "#" || c == ChPct || c == ChComma || c == ";"
                 || c == ChBar) k = CL_SOLO;
        else if (c == "(" || c == ")" || c == ChLBrk || c == ChRBrk) k = CL_BRACK;
        else k = CL_SYM;
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== sv/llt_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Next-state and result logic for one character of the tokenizer.
// Depends on llt_pkg.
module llt_step #(
    parameter int MAX_NAME_LEN      = llt_pkg::MaxNameLenDefault,
    parameter int MAX_COMMENT_DEPTH = llt_pkg::MaxCommentDepthDefault
) (
    input  var llt_pkg::t_state i_state,
    input  var logic [7:0]      i_char,
    input  var llt_pkg::t_cfg   i_cfg,
    output llt_pkg::t_state     o_state,
    output llt_pkg::t_emit      o_emit
);

    localparam int NameCapInt = (MAX_NAME_LEN < llt_pkg::NameCapLimit) ?
                                MAX_NAME_LEN : llt_pkg::NameCapLimit;
    localparam logic [8:0] NameCap = 9'(NameCapInt);
    localparam logic [llt_pkg::DepthW-1:0] DepthMax =
        llt_pkg::DepthW'(MAX_COMMENT_DEPTH);

    function automatic llt_pkg::t_res mk(input llt_pkg::t_kind k, input logic [7:0] tch,
                                         input logic [16:0] h, input logic [8:0] l,
                                         input llt_pkg::t_err e);
        llt_pkg::t_res r;
        r      = '0;
        r.kind = k;
        r.tch  = tch;
        r.hash = h;
        r.len  = l;
        r.err  = e;
        return r;
    endfunction

    function automatic llt_pkg::t_emit emit(input llt_pkg::t_emit e, input llt_pkg::t_res r);
        llt_pkg::t_emit o;
        o = e;
        if (e.n == 2'd0) begin
            o.r0 = r;
            o.n  = 2'd1;
        end else if (e.n == 2'd1) begin
            o.r1 = r;
            o.n  = 2'd2;
        end
        return o;
    endfunction

    function automatic llt_pkg::t_res mk_num(input llt_pkg::t_state s);
        llt_pkg::t_res r;
        r             = mk(llt_pkg::KIND_NUM, 8'd0, 17'd0, 9'd0, llt_pkg::ERR_NONE);
        r.int_part    = s.acc_int;
        r.frac        = s.acc_frac;
        r.frac_digits = s.frac_cnt;
        r.exp_neg     = s.exp_neg;
        r.exp_val     = s.acc_exp;
        return r;
    endfunction

    function automatic llt_pkg::t_state add_char(input llt_pkg::t_state s,
                                                 input logic [7:0] c);
        llt_pkg::t_state o;
        logic [17:0] sum;
        o   = s;
        sum = {1'b0, s.hash} + {10'd0, c};
        if (s.len < NameCap) begin
            o.len  = s.len + 9'd1;
            o.hash = sum[17] ? llt_pkg::HashMax : sum[16:0];
        end
        return o;
    endfunction

    function automatic llt_pkg::t_state start_text(input llt_pkg::t_state s,
                                                   input llt_pkg::t_mode m);
        llt_pkg::t_state o;
        o      = s;
        o.hash = '0;
        o.len  = '0;
        o.held = '0;
        o.mode = m;
        return o;
    endfunction

    function automatic llt_pkg::t_work from_idle(input llt_pkg::t_work w,
                                                 input logic [7:0] c,
                                                 input llt_pkg::t_cfg cfg);
        llt_pkg::t_work o;
        o         = w;
        o.st.mode = llt_pkg::MODE_IDLE;
        unique case (llt_pkg::char_class(c))
            llt_pkg::CL_END: o.em = emit(o.em, mk(llt_pkg::KIND_EOF, 8'd0, 17'd0, 9'd0,
                                                  llt_pkg::ERR_NONE));
            llt_pkg::CL_BLANK: ;
            llt_pkg::CL_VARSTART: o.st = add_char(start_text(o.st, llt_pkg::MODE_VAR), c);
            llt_pkg::CL_LOWER: o.st = add_char(start_text(o.st, llt_pkg::MODE_NAME), c);
            llt_pkg::CL_DIGIT: begin
                o.st.acc_int  = {28'd0, c[3:0]};
                o.st.acc_frac = '0;
                o.st.frac_cnt = '0;
                o.st.exp_neg  = 1'b0;
                o.st.acc_exp  = '0;
                o.st.mode     = llt_pkg::MODE_INT;
            end
            llt_pkg::CL_QUOTE: begin
                o.st       = start_text(o.st, llt_pkg::MODE_QUOTE);
                o.st.quote = c;
            end
            llt_pkg::CL_SYM: begin
                if (c == llt_pkg::ChDot) begin
                    o.st.mode = llt_pkg::MODE_PERIOD;
                end else if (c == llt_pkg::ChSlash) begin
                    o.st      = start_text(o.st, llt_pkg::MODE_SYM);
                    o.st.held = llt_pkg::ChSlash;
                end else begin
                    o.st = add_char(start_text(o.st, llt_pkg::MODE_SYM), c);
                end
            end
            llt_pkg::CL_SOLO: begin
                if (c == llt_pkg::ChPct) begin
                    o.st.mode = llt_pkg::MODE_LINE;
                end else if ((c == llt_pkg::ChComma && cfg.comma_punc) ||
                             (c == llt_pkg::ChBar && cfg.bar_punc)) begin
                    o.em = emit(o.em, mk(llt_pkg::KIND_PUNC, c, 17'd0, 9'd0,
                                         llt_pkg::ERR_NONE));
                end else begin
                    o.em = emit(o.em, mk(llt_pkg::KIND_NAME, 8'd0, {9'd0, c}, 9'd1,
                                         llt_pkg::ERR_NONE));
                end
            end
            llt_pkg::CL_BRACK: begin
                if (c == llt_pkg::ChLBrk) o.st.mode = llt_pkg::MODE_BRACKET;
                else o.em = emit(o.em, mk(llt_pkg::KIND_BRACK, c, 17'd0, 9'd0,
                                          llt_pkg::ERR_NONE));
            end
            default: o.em = emit(o.em, mk(llt_pkg::KIND_ERR, 8'd0, 17'd0, 9'd0,
                                          llt_pkg::ERR_ILLEGAL));
        endcase
        return o;
    endfunction

    function automatic llt_pkg::t_work sym_char(input llt_pkg::t_work w,
                                                input logic [7:0] c,
                                                input llt_pkg::t_cfg cfg);
        llt_pkg::t_work o;
        o = w;
        if (llt_pkg::char_class(c) == llt_pkg::CL_SYM) begin
            if (c == llt_pkg::ChSlash) o.st.held = llt_pkg::ChSlash;
            else o.st = add_char(o.st, c);
        end else begin
            o.em = emit(o.em, mk(llt_pkg::KIND_NAME, 8'd0, o.st.hash, o.st.len,
                                 llt_pkg::ERR_NONE));
            o    = from_idle(o, c, cfg);
        end
        return o;
    endfunction

    function automatic llt_pkg::t_work end_number(input llt_pkg::t_work w,
                                                  input logic [7:0] c,
                                                  input llt_pkg::t_cfg cfg);
        llt_pkg::t_work o;
        o    = w;
        o.em = emit(o.em, mk_num(o.st));
        return from_idle(o, c, cfg);
    endfunction

    function automatic llt_pkg::t_work step_char(input llt_pkg::t_work w,
                                                 input logic [7:0] c,
                                                 input llt_pkg::t_cfg cfg);
        llt_pkg::t_work o;
        llt_pkg::t_cls  cl;
        logic [35:0]    int_x10;
        logic [33:0]    frac_x10;
        logic [19:0]    exp_x10;
        logic [7:0]     h;
        logic           digit;
        o        = w;
        cl       = llt_pkg::char_class(c);
        digit    = (cl == llt_pkg::CL_DIGIT);
        int_x10  = ({4'd0, w.st.acc_int} << 3) + ({4'd0, w.st.acc_int} << 1) + {32'd0, c[3:0]};
        frac_x10 = ({4'd0, w.st.acc_frac} << 3) + ({4'd0, w.st.acc_frac} << 1)
                   + {30'd0, c[3:0]};
        exp_x10  = ({4'd0, w.st.acc_exp} << 3) + ({4'd0, w.st.acc_exp} << 1) + {16'd0, c[3:0]};
        h        = w.st.held;
        unique case (w.st.mode)
            llt_pkg::MODE_VAR, llt_pkg::MODE_NAME: begin
                if (cl == llt_pkg::CL_VARSTART || cl == llt_pkg::CL_LOWER || digit) begin
                    o.st = add_char(o.st, c);
                end else begin
                    o.em = emit(o.em, mk((w.st.mode == llt_pkg::MODE_VAR) ?
                                         llt_pkg::KIND_VAR : llt_pkg::KIND_NAME, 8'd0,
                                         o.st.hash, o.st.len, llt_pkg::ERR_NONE));
                    o    = from_idle(o, c, cfg);
                end
            end
            llt_pkg::MODE_SYM: begin
                if (h == llt_pkg::ChSlash && c == llt_pkg::ChStar) begin
                    if (o.st.len != 9'd0)
                        o.em = emit(o.em, mk(llt_pkg::KIND_NAME, 8'd0, o.st.hash,
                                             o.st.len, llt_pkg::ERR_NONE));
                    o.st.mode  = llt_pkg::MODE_BLOCK;
                    o.st.depth = llt_pkg::DepthW'(1);
                    o.st.held  = '0;
                end else begin
                    o.st.held = '0;
                    if (h == llt_pkg::ChSlash) o.st = add_char(o.st, llt_pkg::ChSlash);
                    o = sym_char(o, c, cfg);
                end
            end
            llt_pkg::MODE_PERIOD: begin
                if (cl == llt_pkg::CL_BLANK || cl == llt_pkg::CL_END) begin
                    o.em = emit(o.em, mk(llt_pkg::KIND_PUNC, llt_pkg::ChDot, 17'd0, 9'd0,
                                         llt_pkg::ERR_NONE));
                    o    = from_idle(o, (cl == llt_pkg::CL_END) ? c : 8'd32, cfg);
                end else begin
                    o.st = add_char(start_text(o.st, llt_pkg::MODE_SYM), llt_pkg::ChDot);
                    o    = sym_char(o, c, cfg);
                end
            end
            llt_pkg::MODE_INT: begin
                if (digit) o.st.acc_int = (int_x10[35:32] != 4'd0) ? llt_pkg::IntMax
                                                                    : int_x10[31:0];
                else if (c == llt_pkg::ChDot) o.st.mode = llt_pkg::MODE_DOT;
                else if (c == llt_pkg::ChE) o.st.mode = llt_pkg::MODE_EXP;
                else o = end_number(o, c, cfg);
            end
            llt_pkg::MODE_DOT: begin
                if (digit) begin
                    o.st.acc_frac = {26'd0, c[3:0]};
                    o.st.frac_cnt = 4'd1;
                    o.st.mode     = llt_pkg::MODE_FRAC;
                end else if (cl == llt_pkg::CL_BLANK) begin
                    o.em      = emit(o.em, mk_num(o.st));
                    o.em      = emit(o.em, mk(llt_pkg::KIND_PUNC, llt_pkg::ChDot, 17'd0,
                                              9'd0, llt_pkg::ERR_NONE));
                    o.st.mode = llt_pkg::MODE_IDLE;
                end else if (cl == llt_pkg::CL_SYM) begin
                    o.em = emit(o.em, mk_num(o.st));
                    o.st = add_char(start_text(o.st, llt_pkg::MODE_SYM), llt_pkg::ChDot);
                    o    = sym_char(o, c, cfg);
                end else begin
                    o.em = emit(o.em, mk_num(o.st));
                    if (cl == llt_pkg::CL_END)
                        o.em = emit(o.em, mk(llt_pkg::KIND_PUNC, llt_pkg::ChDot, 17'd0,
                                             9'd0, llt_pkg::ERR_NONE));
                    else
                        o.em = emit(o.em, mk(llt_pkg::KIND_NAME, 8'd0,
                                             {9'd0, llt_pkg::ChDot}, 9'd1,
                                             llt_pkg::ERR_NONE));
                    // replay this byte ahead of the next one
                    o.st.mode = llt_pkg::MODE_REPLAY;
                    o.st.held = c;
                end
            end
            llt_pkg::MODE_FRAC: begin
                if (digit) begin
                    if (o.st.frac_cnt < llt_pkg::FracMaxD) begin
                        o.st.acc_frac = frac_x10[29:0];
                        o.st.frac_cnt = o.st.frac_cnt + 4'd1;
                    end
                end else if (c == llt_pkg::ChE) o.st.mode = llt_pkg::MODE_EXP;
                else o = end_number(o, c, cfg);
            end
            llt_pkg::MODE_EXP: begin
                if (c == llt_pkg::ChMinus) begin
                    o.st.exp_neg = 1'b1;
                    o.st.mode    = llt_pkg::MODE_ESIGN;
                end else if (c == llt_pkg::ChPlus) begin
                    o.st.mode = llt_pkg::MODE_ESIGN;
                end else if (digit) begin
                    o.st.acc_exp = {12'd0, c[3:0]};
                    o.st.mode    = llt_pkg::MODE_EDIG;
                end else o = end_number(o, c, cfg);
            end
            llt_pkg::MODE_ESIGN: begin
                if (digit) begin
                    o.st.acc_exp = {12'd0, c[3:0]};
                    o.st.mode    = llt_pkg::MODE_EDIG;
                end else o = end_number(o, c, cfg);
            end
            llt_pkg::MODE_EDIG: begin
                if (digit) o.st.acc_exp = (exp_x10[19:16] != 4'd0) ? llt_pkg::ExpMax
                                                                   : exp_x10[15:0];
                else o = end_number(o, c, cfg);
            end
            llt_pkg::MODE_QUOTE: begin
                if (c == o.st.quote) begin
                    o.em      = emit(o.em, mk(llt_pkg::KIND_NAME, 8'd0, o.st.hash,
                                              o.st.len, llt_pkg::ERR_NONE));
                    o.st.mode = llt_pkg::MODE_IDLE;
                end else if (c == llt_pkg::ChNul) begin
                    o.em = emit(o.em, mk(llt_pkg::KIND_ERR, 8'd0, 17'd0, 9'd0,
                                         llt_pkg::ERR_QUOTE));
                    o    = from_idle(o, c, cfg);
                end else o.st = add_char(o.st, c);
            end
            llt_pkg::MODE_BRACKET: begin
                if (c == llt_pkg::ChRBrk) begin
                    o.em      = emit(o.em, mk(llt_pkg::KIND_NIL, 8'd0, 17'd0, 9'd0,
                                              llt_pkg::ERR_NONE));
                    o.st.mode = llt_pkg::MODE_IDLE;
                end else begin
                    o.em = emit(o.em, mk(llt_pkg::KIND_BRACK, llt_pkg::ChLBrk, 17'd0, 9'd0,
                                         llt_pkg::ERR_NONE));
                    o    = from_idle(o, c, cfg);
                end
            end
            llt_pkg::MODE_LINE: begin
                if (c == llt_pkg::ChNl) o.st.mode = llt_pkg::MODE_IDLE;
                else if (c == llt_pkg::ChNul) o = from_idle(o, c, cfg);
            end
            llt_pkg::MODE_BLOCK: begin
                o.st.held = '0;
                if (c == llt_pkg::ChNul) begin
                    o.st.depth = '0;
                    o.em       = emit(o.em, mk(llt_pkg::KIND_ERR, 8'd0, 17'd0, 9'd0,
                                               llt_pkg::ERR_COMMENT));
                    o          = from_idle(o, c, cfg);
                end else if (h == llt_pkg::ChStar && c == llt_pkg::ChSlash) begin
                    if (cfg.nested && o.st.depth > llt_pkg::DepthW'(1)) begin
                        o.st.depth = o.st.depth - llt_pkg::DepthW'(1);
                    end else begin
                        o.st.depth = '0;
                        o.st.mode  = llt_pkg::MODE_IDLE;
                    end
                end else if (h == llt_pkg::ChSlash && c == llt_pkg::ChStar && cfg.nested) begin
                    if (o.st.depth < DepthMax) o.st.depth = o.st.depth + llt_pkg::DepthW'(1);
                end else if (c == llt_pkg::ChStar) begin
                    o.st.held = llt_pkg::ChStar;
                end else if (c == llt_pkg::ChSlash && cfg.nested) begin
                    o.st.held = llt_pkg::ChSlash;
                end
            end
            default: o = from_idle(o, c, cfg);
        endcase
        return o;
    endfunction

    llt_pkg::t_work w_in;
    llt_pkg::t_work w_pre;
    llt_pkg::t_work w_out;

    always_comb begin
        w_in.st = i_state;
        w_in.em = '0;
        w_pre   = w_in;
        // a held byte is handled first, as if it had arrived on its own
        if (i_state.mode == llt_pkg::MODE_REPLAY) begin
            w_pre.st.held = '0;
            w_pre         = from_idle(w_pre, i_state.held, i_cfg);
        end
        w_out = step_char(w_pre, i_char, i_cfg);
    end

    assign o_state = w_out.st;
    assign o_emit  = w_out.em;

endmodule
`default_nettype wire

// ===== sv/llt_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on llt_pkg.
module llt_out_fifo (
    input  var logic           i_clk,
    input  var logic           i_rst_n,
    input  var logic           i_push,
    input  var llt_pkg::t_emit i_emit,
    input  var logic           i_pop,
    output llt_pkg::t_res      o_head,
    output logic               o_head_last,
    output logic               o_valid,
    output llt_pkg::t_fifo_stat o_stat
);

    llt_pkg::t_res r_mem [llt_pkg::FifoDepth];
    logic          r_last [llt_pkg::FifoDepth];
    logic [1:0]    r_rd;
    logic [1:0]    r_wr;
    logic [2:0]    r_count;
    logic [1:0]    n_rd;
    logic [1:0]    n_wr;
    logic [2:0]    n_count;
    logic [1:0]    push_n;
    logic          pop_go;

    assign push_n  = i_push ? i_emit.n : 2'd0;
    assign pop_go  = i_pop && (r_count != 3'd0);
    assign n_wr    = r_wr + push_n;
    assign n_rd    = r_rd + {1'b0, pop_go};
    assign n_count = r_count + {1'b0, push_n} - {2'b0, pop_go};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr]  <= i_emit.r0;
            r_last[r_wr] <= (push_n == 2'd1);
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr + 2'd1]  <= i_emit.r1;
            r_last[r_wr + 2'd1] <= 1'b1;
        end
    end

    assign o_head        = r_mem[r_rd];
    assign o_head_last   = r_last[r_rd];
    assign o_valid       = (r_count != 3'd0);
    assign o_stat.count  = r_count;
    assign o_stat.space2 = (r_count <= 3'(llt_pkg::FifoDepth - 2));

endmodule
`default_nettype wire

// ===== sv/logic_language_tokenizer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the logic-language tokenizer: input register, scan state,
// configuration registers and result queue. Depends on llt_pkg, llt_step, llt_out_fifo.
//
// One source character per request on the input channel, one token per request
// on the output channel. A character sits in an input register, the scan logic
// works out the next scan state and zero, one or two tokens, and the tokens land
// in a four-entry result queue whose head drives the output ports. With the
// output side taking every cycle the block accepts one character per clock; a
// character that yields two tokens holds the output for both of them, so a stream
// dense in such characters drains at one token per clock, set by the single read
// port of the result queue. Tokens are usually reported with the character that
// follows them, since periods, brackets and comment openers need lookahead;
// o_last marks the final token of a character.
// Configuration writes take effect at once and are meant for idle periods.
module logic_language_tokenizer_unit #(
    parameter int MAX_NAME_LEN      = llt_pkg::MaxNameLenDefault,
    parameter int MAX_COMMENT_DEPTH = llt_pkg::MaxCommentDepthDefault
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    // configuration
    input  var logic        i_cfg_we,
    input  var logic [1:0]  i_cfg_index,
    input  var logic        i_cfg_data,
    // character requests
    input  var logic        i_in_valid,
    output logic            o_in_ready,
    input  var logic [7:0]  i_in_char,
    // token requests
    output logic            o_out_valid,
    input  var logic        i_out_ready,
    output logic [2:0]      o_token_kind,
    output logic [7:0]      o_token_char,
    output logic [16:0]     o_name_hash,
    output logic [8:0]      o_name_length,
    output logic [31:0]     o_int_part,
    output logic [29:0]     o_frac_value,
    output logic [3:0]      o_frac_digits,
    output logic            o_exp_negative,
    output logic [15:0]     o_exp_value,
    output logic [1:0]      o_error_code,
    output logic            o_last
);

    llt_pkg::t_cfg       r_cfg;
    llt_pkg::t_state     r_state;
    llt_pkg::t_state     n_state;
    llt_pkg::t_emit      step_emit;
    llt_pkg::t_res       head;
    llt_pkg::t_fifo_stat fifo_stat;
    logic                r_in_vld;
    logic [7:0]          r_in_char;
    logic                go;

    // advance the held character only when the queue can take two tokens
    assign go         = r_in_vld && fifo_stat.space2;
    assign o_in_ready = !r_in_vld || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nested     <= 1'b1;
            r_cfg.comma_punc <= 1'b0;
            r_cfg.bar_punc   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                llt_pkg::CFG_NESTED: r_cfg.nested     <= i_cfg_data;
                llt_pkg::CFG_COMMA:  r_cfg.comma_punc <= i_cfg_data;
                llt_pkg::CFG_BAR:    r_cfg.bar_punc   <= i_cfg_data;
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // input register: hold the character until the scan logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_char <= i_in_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llt_pkg::StateReset;
        end else if (go) begin
            r_state <= n_state;
        end
    end

    llt_step #(
        .MAX_NAME_LEN      (MAX_NAME_LEN),
        .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
    ) u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_emit  (step_emit)
    );

    llt_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (go),
        .i_emit      (step_emit),
        .i_pop       (i_out_ready),
        .o_head      (head),
        .o_head_last (o_last),
        .o_valid     (o_out_valid),
        .o_stat      (fifo_stat)
    );

    assign o_token_kind   = head.kind;
    assign o_token_char   = head.tch;
    assign o_name_hash    = head.hash;
    assign o_name_length  = head.len;
    assign o_int_part     = head.int_part;
    assign o_frac_value   = head.frac;
    assign o_frac_digits  = head.frac_digits;
    assign o_exp_negative = head.exp_neg;
    assign o_exp_value    = head.exp_val;
    assign o_error_code   = head.err;

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.count <= 3'(llt_pkg::FifoDepth))
        else $error("result queue overfilled");

    a_hold_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !go) |=> (r_in_vld && $stable(r_in_char)))
        else $error("stalled character lost");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state.mode == llt_pkg::MODE_IDLE))
        else $error("scan state not idle after reset");

    a_valid_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid == (fifo_stat.count != 3'd0))
        else $error("output valid disagrees with queue fill");
`endif

endmodule
`default_nettype wire
